[design/u8v_pkg.sv]
`default_nettype none

package u8v_pkg;

    // Error kinds reported with the verdict.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NUL        = 3'd1;
    localparam logic [2:0] ERR_BAD_LEAD   = 3'd2;
    localparam logic [2:0] ERR_BAD_CONT   = 3'd3;
    localparam logic [2:0] ERR_OVERLONG   = 3'd4;
    localparam logic [2:0] ERR_BEYOND_MAX = 3'd5;
    localparam logic [2:0] ERR_SURROGATE  = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd7;

    // Byte classes.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_MAX    = 8'hF4;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    // Code point limits.
    localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;
    localparam logic [20:0] CODE_MAX       = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW       = 21'h00D800;
    localparam logic [20:0] SURR_HIGH      = 21'h00DFFF;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]  bytes_remaining;
        logic [2:0]  sequence_length;
        logic [20:0] code_point;
        logic        error_seen;
        logic [2:0]  first_error;
    } decode_state_t;

    // Verdict for one string.
    typedef struct packed {
        logic       text_ok;
        logic [2:0] error_kind;
    } verdict_t;

endpackage

`default_nettype wire

[design/u8v_in_if.sv]
`default_nettype none

interface u8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_item;
    logic       no_byte;

    modport source (output valid, output data_byte, output last_item, output no_byte,
                    input ready);
    modport sink (input valid, input data_byte, input last_item, input no_byte,
                  output ready);
endinterface

`default_nettype wire

[design/u8v_out_if.sv]
`default_nettype none

interface u8v_out_if;
    logic       valid;
    logic       ready;
    logic       text_ok;
    logic [2:0] error_kind;

    modport source (output valid, output text_ok, output error_kind, input ready);
    modport sink (input valid, input text_ok, input error_kind, output ready);
endinterface

`default_nettype wire

[design/u8v_step.sv]
`default_nettype none

module u8v_step
    import u8v_pkg::*;
(
    input  decode_state_t cur,
    input  logic [7:0]    data_byte,
    input  logic          last_item,
    input  logic          no_byte,
    output decode_state_t nxt,
    output verdict_t      res
);

    decode_state_t st;
    logic [20:0]   cp_shift;
    logic          flag;
    logic [2:0]    kind;

    always_comb
    begin
        st       = cur;
        cp_shift = {cur.code_point[14:0], data_byte[5:0]};
        flag     = 1'b0;
        kind     = ERR_NONE;

        // Decode one byte unless there is none or the string has already failed.
        if (!no_byte && !cur.error_seen)
        begin
            if (cur.bytes_remaining == 2'd0)
            begin
                // Expecting a lead byte.
                priority if (data_byte == 8'h00)
                begin
                    flag = 1'b1;
                    kind = ERR_NUL;
                end
                else if (data_byte < ASCII_LIMIT)
                begin
                    // Plain ASCII leaves the state alone.
                    st = cur;
                end
                else if (data_byte < LEAD2_MIN || data_byte > LEAD_MAX)
                begin
                    flag = 1'b1;
                    kind = ERR_BAD_LEAD;
                end
                else if (data_byte < LEAD3_MIN)
                begin
                    st.sequence_length = 3'd2;
                    st.code_point      = {16'd0, data_byte[4:0]};
                    st.bytes_remaining = 2'd1;
                end
                else if (data_byte < LEAD4_MIN)
                begin
                    st.sequence_length = 3'd3;
                    st.code_point      = {17'd0, data_byte[3:0]};
                    st.bytes_remaining = 2'd2;
                end
                else
                begin
                    st.sequence_length = 3'd4;
                    st.code_point      = {18'd0, data_byte[2:0]};
                    st.bytes_remaining = 2'd3;
                end
            end
            else if ((data_byte & CONT_MASK) != CONT_TAG)
            begin
                // A NUL or any other non-continuation byte inside a sequence.
                flag = 1'b1;
                kind = ERR_BAD_CONT;
            end
            else
            begin
                st.code_point      = cp_shift;
                st.bytes_remaining = cur.bytes_remaining - 2'd1;
                // Range checks once the sequence is complete, in priority order.
                if (cur.bytes_remaining == 2'd1)
                begin
                    priority if (cur.sequence_length == 3'd3 && cp_shift < MIN_THREE_BYTE)
                    begin
                        flag = 1'b1;
                        kind = ERR_OVERLONG;
                    end
                    else if (cur.sequence_length == 3'd4 && cp_shift < MIN_FOUR_BYTE)
                    begin
                        flag = 1'b1;
                        kind = ERR_OVERLONG;
                    end
                    else if (cp_shift > CODE_MAX)
                    begin
                        flag = 1'b1;
                        kind = ERR_BEYOND_MAX;
                    end
                    else if (cp_shift >= SURR_LOW && cp_shift <= SURR_HIGH)
                    begin
                        flag = 1'b1;
                        kind = ERR_SURROGATE;
                    end
                    else
                    begin
                        flag = 1'b0;
                    end
                end
            end
        end

        if (flag)
        begin
            st.error_seen  = 1'b1;
            st.first_error = kind;
        end

        // At the end of the string an open sequence counts as truncated, unless an error came first.
        if (last_item && st.bytes_remaining != 2'd0 && !st.error_seen)
        begin
            st.error_seen  = 1'b1;
            st.first_error = ERR_TRUNCATED;
        end

        res.text_ok    = !st.error_seen;
        res.error_kind = st.first_error;
        nxt            = last_item ? '0 : st;
    end

endmodule

`default_nettype wire

[design/utf8_stream_validator.sv]
// A last item is held in the input register, then its verdict in the output register.
// Throughput: one byte per cycle; the per-byte decode sits between the input
// register and the state and verdict registers, and the input stalls only while a
// finished verdict waits at the output and the item held is also a last item.
// Reset: rst_n clears the decoder state and both valid flags asynchronously.
`default_nettype none

module utf8_stream_validator
    import u8v_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    u8v_in_if.sink      byte_stream,
    u8v_out_if.source   verdict
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_data_reg;
    logic          in_last_reg;
    logic          in_none_reg;
    decode_state_t state_reg;
    decode_state_t state_next;
    decode_state_t state_step;
    verdict_t      res;
    logic          out_valid_reg;
    logic          out_valid_next;
    verdict_t      out_reg;
    logic          out_free;
    logic          advance;
    logic          in_accept;

    u8v_step step (
        .cur       (state_reg),
        .data_byte (in_data_reg),
        .last_item (in_last_reg),
        .no_byte   (in_none_reg),
        .nxt       (state_step),
        .res       (res)
    );

    // The held request moves on unless it needs the output slot and that is full.
    assign out_free  = !out_valid_reg || verdict.ready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_accept = byte_stream.valid && byte_stream.ready;

    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign state_next     = advance ? state_step : state_reg;
    assign out_valid_next = (advance && in_last_reg) || (out_valid_reg && !verdict.ready);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_item;
            in_none_reg <= byte_stream.no_byte;
        end
        if (advance && in_last_reg)
        begin
            out_reg <= res;
        end
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.text_ok    = out_reg.text_ok;
    assign verdict.error_kind = out_reg.error_kind;

endmodule

`default_nettype wire

[design/u8v_checker.sv]
`default_nettype none

module u8v_checker
    import u8v_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       in_last,
    input wire       out_valid,
    input wire       out_ready,
    input wire       out_text_ok,
    input wire [2:0] out_error_kind
);

    // A stalled verdict holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_text_ok)
            && $stable(out_error_kind))
        else $error("verdict changed while stalled");

    // The verdict flag and the error kind agree.
    a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_text_ok == (out_error_kind == ERR_NONE)))
        else $error("text_ok disagrees with error_kind");

    // A new verdict appears only after a last item was taken.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
        else $error("verdict without a closing request");

    // With the output slot empty the input never stalls.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind utf8_stream_validator u8v_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (byte_stream.valid),
    .in_ready       (byte_stream.ready),
    .in_last        (byte_stream.last_item),
    .out_valid      (verdict.valid),
    .out_ready      (verdict.ready),
    .out_text_ok    (verdict.text_ok),
    .out_error_kind (verdict.error_kind)
);

`default_nettype wire
